[rtl/wim_pkg.sv]
package wim_pkg;

  localparam int WORD_W                = 64;
  localparam int DIGIT_W               = 16;
  localparam int DIGITS                = WORD_W / DIGIT_W;
  localparam int OPERAND_BYTES_DEFAULT = 256;

  typedef struct packed {
    logic [WORD_W-1:0] multiplicand_word;
    logic [WORD_W-1:0] multiplier_word;
    logic              final_pair;
  } operand_t;

  typedef struct packed {
    logic [WORD_W-1:0] product_word;
    logic              product_last;
  } product_t;

  // Control from the sequencer to the digit-serial multiply-add unit
  typedef struct packed {
    logic load;
    logic step;
  } mac_ctrl_t;

endpackage

[rtl/wide_integer_multiplier.sv]
// Sequence: N = OPERAND_BYTES/8 words per operand. After the transaction with final_pair,
//   the multiply runs N rows of N column steps and a carry write each, then the product
//   words are read out of the accumulator, each after the previous one is taken.
// Each 64x64 partial product takes operand fetch, load, 4 digit steps of the 64x16 multiplier
//   and accumulator write-back; word pairs are taken one at a time while operand_stall is low.
// Reset: clears the sequencer, counters and load position; the stores keep their contents.
module wide_integer_multiplier #(
  parameter int OPERAND_BYTES = wim_pkg::OPERAND_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              operand_valid,
  output logic              operand_stall,
  input  wim_pkg::operand_t operand,
  output logic              product_valid,
  input  logic              product_stall,
  output wim_pkg::product_t product
);
  import wim_pkg::*;

  localparam int N   = OPERAND_BYTES / 8;
  localparam int PW  = 2 * N;
  localparam int WAW = (N > 1) ? $clog2(N) : 1;
  localparam int PAW = $clog2(PW);
  localparam int DCW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_FETCH    = 9'b000000010,
    S_LOAD     = 9'b000000100,
    S_MUL      = 9'b000001000,
    S_WB       = 9'b000010000,
    S_CARRY    = 9'b000100000,
    S_OUT_RD   = 9'b001000000,
    S_OUT_LD   = 9'b010000000,
    S_OUT_WAIT = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [WAW-1:0]    lp;         // load position
  logic [WAW-1:0]    row;        // multiplier word index
  logic [WAW-1:0]    col;        // multiplicand word index
  logic [DCW-1:0]    dc;         // digit step count
  logic [PAW-1:0]    k;          // product word being sent
  logic              first_row;  // accumulator reads as zero on the first row
  logic [WORD_W-1:0] carry;

  logic              out_phase;
  logic              op_acc;
  logic              last_word;

  logic [WORD_W-1:0] mcand_rd;
  logic [WORD_W-1:0] mplier_rd;
  logic [WORD_W-1:0] acc_rd;
  logic              acc_wr_en;
  logic [PAW-1:0]    acc_wr_addr;
  logic [WORD_W-1:0] acc_wr_data;
  logic [PAW-1:0]    acc_rd_addr;

  mac_ctrl_t         mac_ctrl;
  logic [WORD_W-1:0] mac_addend;
  logic [WORD_W-1:0] prod_lo;
  logic [WORD_W-1:0] prod_hi;

  product_t          product_q;

  assign out_phase = (state == S_OUT_RD) || (state == S_OUT_LD) || (state == S_OUT_WAIT);

  // Take operand words when idle; while the product drains, take all but the
  // final pair, since the final pair starts a multiply on the busy accumulator.
  assign operand_stall = !((state == S_IDLE) || (out_phase && !operand.final_pair));
  assign op_acc        = operand_valid && !operand_stall;
  assign last_word     = (k == PAW'(PW - 1));

  // Operand stores: written at the load position, read by the multiply loop
  wim_ram #(.WIDTH(WORD_W), .DEPTH(N)) u_mcand_ram (
    .clk     (clk),
    .wr_en   (op_acc),
    .wr_addr (lp),
    .wr_data (operand.multiplicand_word),
    .rd_addr (col),
    .rd_data (mcand_rd)
  );

  wim_ram #(.WIDTH(WORD_W), .DEPTH(N)) u_mplier_ram (
    .clk     (clk),
    .wr_en   (op_acc),
    .wr_addr (lp),
    .wr_data (operand.multiplier_word),
    .rd_addr (row),
    .rd_data (mplier_rd)
  );

  // Product accumulator: row/column sum during the multiply, word index when draining
  assign acc_wr_en   = (state == S_WB) || (state == S_CARRY);
  assign acc_wr_addr = (state == S_CARRY) ? (PAW'(row) + PAW'(N)) : (PAW'(row) + PAW'(col));
  assign acc_wr_data = (state == S_CARRY) ? carry : prod_lo;
  assign acc_rd_addr = out_phase ? k : (PAW'(row) + PAW'(col));

  wim_ram #(.WIDTH(WORD_W), .DEPTH(PW)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_wr_addr),
    .wr_data (acc_wr_data),
    .rd_addr (acc_rd_addr),
    .rd_data (acc_rd)
  );

  // Digit-serial multiply-add: multiplicand * multiplier + accumulator word + carry
  assign mac_ctrl.load = (state == S_LOAD);
  assign mac_ctrl.step = (state == S_MUL);
  assign mac_addend    = first_row ? '0 : acc_rd;

  wim_digit_mac u_mac (
    .clk          (clk),
    .ctrl         (mac_ctrl),
    .multiplicand (mcand_rd),
    .multiplier   (mplier_rd),
    .addend       (mac_addend),
    .carry_in     (carry),
    .prod_lo      (prod_lo),
    .prod_hi      (prod_hi)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (op_acc && operand.final_pair) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: state_next = S_LOAD;
      S_LOAD:  state_next = S_MUL;
      S_MUL: begin
        if (dc == DCW'(DIGITS - 1)) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        state_next = (col == WAW'(N - 1)) ? S_CARRY : S_FETCH;
      end
      S_CARRY: begin
        state_next = (row == WAW'(N - 1)) ? S_OUT_RD : S_FETCH;
      end
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: state_next = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (!product_stall) begin
          state_next = last_word ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lp            <= '0;
      row           <= '0;
      col           <= '0;
      dc            <= '0;
      k             <= '0;
      first_row     <= 1'b1;
      carry         <= '0;
      product_valid <= 1'b0;
    end else begin
      state <= state_next;

      // Advance the load position; wrap after a full operand, return to zero on final
      if (op_acc) begin
        if (operand.final_pair || (lp == WAW'(N - 1))) begin
          lp <= '0;
        end else begin
          lp <= lp + 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (op_acc && operand.final_pair) begin
            row       <= '0;
            col       <= '0;
            carry     <= '0;
            first_row <= 1'b1;
          end
        end
        S_LOAD: dc <= '0;
        S_MUL:  dc <= dc + 1'b1;
        S_WB: begin
          // Hold the high half as the carry into the next column
          carry <= prod_hi;
          if (col != WAW'(N - 1)) begin
            col <= col + 1'b1;
          end
        end
        S_CARRY: begin
          carry <= '0;
          col   <= '0;
          if (row != WAW'(N - 1)) begin
            row       <= row + 1'b1;
            first_row <= 1'b0;
          end else begin
            k <= '0;
          end
        end
        S_OUT_LD: begin
          product_valid          <= 1'b1;
          product_q.product_word <= acc_rd;
          product_q.product_last <= last_word;
        end
        S_OUT_WAIT: begin
          if (!product_stall) begin
            product_valid <= 1'b0;
            k             <= k + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign product = product_q;

  // The output register only carries a transaction while the sequencer waits on it
  a_valid_in_wait: assert property (@(posedge clk) disable iff (rst)
    product_valid |-> (state == S_OUT_WAIT))
    else $error("product valid outside the output wait state");

  // A multiply only starts from idle
  a_final_from_idle: assert property (@(posedge clk) disable iff (rst)
    (op_acc && operand.final_pair) |-> (state == S_IDLE))
    else $error("final pair taken while not idle");

  // Every row starts with a cleared carry
  a_row_carry_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOAD) && (col == '0)) |-> (carry == '0))
    else $error("carry not cleared at row start");

  // Drop back to idle after the most significant product word is taken
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (product_valid && !product_stall && product.product_last) |=> (state == S_IDLE))
    else $error("not idle after last product word");

endmodule

[rtl/wim_ram.sv]
module wim_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/wim_digit_mac.sv]
module wim_digit_mac (
  input  logic                        clk,
  input  wim_pkg::mac_ctrl_t          ctrl,
  input  logic [wim_pkg::WORD_W-1:0]  multiplicand,
  input  logic [wim_pkg::WORD_W-1:0]  multiplier,
  input  logic [wim_pkg::WORD_W-1:0]  addend,
  input  logic [wim_pkg::WORD_W-1:0]  carry_in,
  output logic [wim_pkg::WORD_W-1:0]  prod_lo,
  output logic [wim_pkg::WORD_W-1:0]  prod_hi
);
  import wim_pkg::*;

  localparam int PPW = WORD_W + DIGIT_W;
  localparam int SW  = WORD_W + DIGIT_W + 1;

  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_sh;
  logic [WORD_W-1:0] x_sh;
  logic [WORD_W-1:0] lo_sh;
  logic [WORD_W:0]   h_q;
  logic [PPW-1:0]    pp;
  logic [SW-1:0]     sum;

  // One multiplier digit against the whole multiplicand, plus running high part
  // and the matching digit of the addend.
  assign pp  = a_q * b_sh[DIGIT_W-1:0];
  assign sum = SW'(h_q) + SW'(pp) + SW'(x_sh[DIGIT_W-1:0]);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_q  <= multiplicand;
      b_sh <= multiplier;
      x_sh <= addend;
      h_q  <= {1'b0, carry_in};
    end else if (ctrl.step) begin
      b_sh  <= b_sh >> DIGIT_W;
      x_sh  <= x_sh >> DIGIT_W;
      lo_sh <= {sum[DIGIT_W-1:0], lo_sh[WORD_W-1:DIGIT_W]};
      h_q   <= sum[SW-1:DIGIT_W];
    end
  end

  assign prod_lo = lo_sh;
  assign prod_hi = h_q[WORD_W-1:0];

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

localparam int OPERAND_WORDS = wim_pkg::OPERAND_BYTES_DEFAULT / 8;
localparam int PRODUCT_WORDS = 2 * OPERAND_WORDS;

// Tracks the operand stores and predicts every product word in order.
class product_tracker;
  logic [63:0] multiplicand_words [OPERAND_WORDS];
  logic [63:0] multiplier_words [OPERAND_WORDS];
  int unsigned load_pos;
  wim_pkg::product_t expected_words [$];
  int errors;

  function new();
    load_pos = 0;
    errors = 0;
  endfunction

  // Store one accepted word pair; on the final pair, queue the full product.
  function void note_pair(wim_pkg::operand_t pair);
    logic [OPERAND_WORDS*64-1:0] multiplicand;
    logic [OPERAND_WORDS*64-1:0] multiplier;
    logic [PRODUCT_WORDS*64-1:0] full_product;
    wim_pkg::product_t word;
    int k;
    multiplicand_words[load_pos] = pair.multiplicand_word;
    multiplier_words[load_pos] = pair.multiplier_word;
    if (!pair.final_pair) begin
      load_pos = (load_pos + 1) % OPERAND_WORDS;
      return;
    end
    load_pos = 0;
    for (k = 0; k < OPERAND_WORDS; k++) begin
      multiplicand[k*64 +: 64] = multiplicand_words[k];
      multiplier[k*64 +: 64] = multiplier_words[k];
    end
    full_product = multiplicand;
    full_product = full_product * multiplier;
    for (k = 0; k < PRODUCT_WORDS; k++) begin
      word.product_word = full_product[k*64 +: 64];
      word.product_last = (k == PRODUCT_WORDS - 1);
      expected_words.push_back(word);
    end
  endfunction

  // Compare one accepted product word against the oldest prediction.
  function void check_word(wim_pkg::product_t got);
    wim_pkg::product_t want;
    if (expected_words.size() == 0) begin
      $error("product word %h arrived with nothing expected", got.product_word);
      errors++;
      return;
    end
    want = expected_words.pop_front();
    if (got.product_word !== want.product_word) begin
      $error("product_word: expected %h, actual %h", want.product_word, got.product_word);
      errors++;
    end
    if (got.product_last !== want.product_last) begin
      $error("product_last: expected %b, actual %b", want.product_last, got.product_last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module testbench;
  // Stop issuing new sequences once this many pairs have gone in.
  localparam int ITEMS = 410;
  // Longest stretch without any transaction: one full multiply plus margin, taken
  // several times over to allow for sender gaps and receiver stalls.
  localparam int QUIET_LIMIT = 4 * OPERAND_WORDS * (7 * OPERAND_WORDS + 1) + 2000;
  // Cycles to keep watching for stray product words after the last one.
  localparam int DRAIN_CYCLES = 60;

  logic              clk;
  logic              rst;
  logic              operand_valid;
  logic              operand_stall;
  wim_pkg::operand_t operand;
  logic              product_valid;
  logic              product_stall;
  wim_pkg::product_t product;

  product_tracker tracker = new();

  // Idle percentages for each side; the stimulus moves them through the phases.
  int send_idle_pct;
  int recv_idle_pct;
  int sent;

  wide_integer_multiplier uut (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_stall (operand_stall),
    .operand       (operand),
    .product_valid (product_valid),
    .product_stall (product_stall),
    .product       (product)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the product side at random; the rate follows the current phase.
  always @(posedge clk) begin
    product_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watch both channels at each edge: feed accepted pairs to the predictor,
  // check accepted product words against it.
  always @(posedge clk) begin
    if (!rst) begin
      if (operand_valid && !operand_stall) begin
        tracker.note_pair(operand);
      end
      if (product_valid && !product_stall) begin
        tracker.check_word(product);
      end
    end
  end

  // End the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (operand_valid && !operand_stall) || (product_valid && !product_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench NOT OK");
    $finish;
  end

  // Mostly dense random words, with a share of all ones, zero and single set bits.
  function automatic logic [63:0] random_word();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return '1;
    end else if (roll == 1) begin
      return '0;
    end else if (roll == 2) begin
      return 64'd1 << $urandom_range(0, 63);
    end
    return {$urandom, $urandom};
  endfunction

  // Offer one word pair and hold it until the block takes it.
  task automatic send_pair(input logic [63:0] mcand, input logic [63:0] mplier,
                           input logic last_pair);
    wim_pkg::operand_t pair;
    pair.multiplicand_word = mcand;
    pair.multiplier_word   = mplier;
    pair.final_pair        = last_pair;
    // Pick the idle mix: sender light and receiver heavy, then swapped, then none.
    if (sent < ITEMS / 3) begin
      send_idle_pct = 30;
      recv_idle_pct = 65;
    end else if (sent < 2 * ITEMS / 3) begin
      send_idle_pct = 65;
      recv_idle_pct = 30;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      operand_valid <= 1'b0;
      @(posedge clk);
    end
    operand_valid <= 1'b1;
    operand       <= pair;
    @(posedge clk);
    while (operand_stall) begin
      @(posedge clk);
    end
    sent++;
  endtask

  initial begin : stimulus
    int k;
    int seq_len;
    int roll;
    bit first_random;
    rst           = 1'b1;
    operand_valid = 1'b0;
    operand       = '0;
    send_idle_pct = 30;
    recv_idle_pct = 65;
    sent          = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Largest operands: fill every store entry with all ones, so no later
    // multiply can touch a word that was never written.
    for (k = 0; k < OPERAND_WORDS; k++) begin
      send_pair('1, '1, k == OPERAND_WORDS - 1);
    end
    // Early final pairs: only the low words change, the rest carry over.
    send_pair('0, '0, 1'b1);
    send_pair(64'd1, '1, 1'b1);
    send_pair(64'h8000_0000_0000_0000, 64'd1, 1'b0);
    send_pair('1, 64'h8000_0000_0000_0000, 1'b1);

    // Random sequences: an overlong load first, then full-width operands half the time, short
    // early-final loads, and overlong loads that wrap the load position.
    first_random = 1'b1;
    while (sent < ITEMS) begin
      roll = $urandom_range(0, 19);
      if (first_random || roll < 3) begin
        seq_len = $urandom_range(OPERAND_WORDS + 1, OPERAND_WORDS + 8);
      end else if (roll < 10) begin
        seq_len = $urandom_range(1, 8);
      end else begin
        seq_len = OPERAND_WORDS;
      end
      first_random = 1'b0;
      for (k = 0; k < seq_len; k++) begin
        send_pair(random_word(), random_word(), k == seq_len - 1);
      end
    end
    operand_valid <= 1'b0;

    // Drain: wait out the last multiply, then watch for stray words.
    @(negedge clk);
    while (tracker.pending() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
